// ===== rtl/core/nsv_pkg.sv =====
`timescale 1ns / 1ps

package nsv_pkg;

    // Default sizes
    localparam int MAX_LENGTH_DEF  = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed result field widths
    localparam int IDX_W = 5;
    localparam int NBR_W = 6;

    // Neighbor code for "no smaller value"
    localparam logic [NBR_W-1:0] NBR_NONE = {NBR_W{1'b1}};

    // Stack shift control handed to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } nsv_shift_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } nsv_state_t;

endpackage

// ===== rtl/core/nsv_cell.sv =====
`timescale 1ns / 1ps

module nsv_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int POS_W       = 5,
    parameter int NBR_W       = 6
) (
    input  logic                          clk,
    input  nsv_pkg::nsv_shift_t           shift,
    input  logic signed [VALUE_WIDTH-1:0] up_value,
    input  logic        [POS_W-1:0]       up_pos,
    input  logic        [NBR_W-1:0]       up_left,
    input  logic signed [VALUE_WIDTH-1:0] dn_value,
    input  logic        [POS_W-1:0]       dn_pos,
    input  logic        [NBR_W-1:0]       dn_left,
    output logic signed [VALUE_WIDTH-1:0] value,
    output logic        [POS_W-1:0]       pos,
    output logic        [NBR_W-1:0]       left
);
    import nsv_pkg::*;

    logic signed [VALUE_WIDTH-1:0] value_reg, value_next;
    logic        [POS_W-1:0]       pos_reg, pos_next;
    logic        [NBR_W-1:0]       left_reg, left_next;

    // Take the entry from above on push, from below on pop, else hold
    always_comb
    begin
        value_next = value_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        if (shift.push)
        begin
            value_next = up_value;
            pos_next   = up_pos;
            left_next  = up_left;
        end
        else if (shift.pop)
        begin
            value_next = dn_value;
            pos_next   = dn_pos;
            left_next  = dn_left;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pos_reg   <= pos_next;
        left_reg  <= left_next;
    end

    assign value = value_reg;
    assign pos   = pos_reg;
    assign left  = left_reg;

endmodule

// ===== rtl/core/nearest_smaller_values_stack.sv =====
`timescale 1ns / 1ps

// All nearest smaller values over a stream of signed samples.
// Input channel: in_valid / in_stall with sample_value and sequence_end; a
// request is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with element_index, left_smaller,
// right_smaller, overflow and last_of_item, zero or more results per request.
// cfg_wr_en / cfg_wr_data write repeat_mode (reset 1); the user must write it
// only while the block is idle, as the block itself does not enforce this.
// The stack is a row of cells, top in cell 0; a push shifts every entry one
// cell down, a pop shifts one cell up. Each scan cycle of the sequencer does
// one compare against the top cell and either one pop or the push; a pop
// waits while a held result is stalled. The next sample is taken in the same
// cycle as the push. A sequence end flushes the stack entry by entry, and the
// block returns to idle before the next sample is taken.
// The first result of a sample is registered from the scan state when it
// pops an entry or overflows without an end, and from the flush state when
// it comes from the flush. While a result is held with out_stall high, the
// result register holds and the sequencer waits on any further result. Reset
// empties the stack, clears the position and sets repeat_mode to 1.
module nearest_smaller_values_stack #(
    parameter int MAX_LENGTH  = nsv_pkg::MAX_LENGTH_DEF,
    parameter int VALUE_WIDTH = nsv_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] sample_value,
    input  logic                          sequence_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nsv_pkg::IDX_W-1:0]     element_index,
    output logic [nsv_pkg::NBR_W-1:0]     left_smaller,
    output logic [nsv_pkg::NBR_W-1:0]     right_smaller,
    output logic                          overflow,
    output logic                          last_of_item
);
    import nsv_pkg::*;

    localparam int POS_W = $clog2(MAX_LENGTH);
    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LENGTH);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    nsv_state_t state_reg, state_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    logic end_reg, end_next;
    logic mode_reg, mode_next;
    logic flush_ovf_reg, flush_ovf_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;

    logic out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [NBR_W-1:0] out_left_reg, out_left_next;
    logic [NBR_W-1:0] out_right_reg, out_right_next;
    logic out_ovf_reg, out_ovf_next;
    logic out_last_reg, out_last_next;

    // Stack cells
    logic signed [VALUE_WIDTH-1:0] cell_value [MAX_LENGTH];
    logic        [POS_W-1:0]       cell_pos   [MAX_LENGTH];
    logic        [NBR_W-1:0]       cell_left  [MAX_LENGTH];
    nsv_shift_t shift;
    logic [NBR_W-1:0] push_left;

    logic in_accept;
    logic out_free;
    logic emit;
    logic length_ovf;
    logic top_gt;
    logic next_gt;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign length_ovf = (pos_reg >= CNT_MAX);
    assign top_gt  = (count_reg != '0) && (cell_value[0] > key_reg);
    assign next_gt = (count_reg > CNT_ONE) && (cell_value[1] > key_reg);

    // Left neighbor fixed at push time
    always_comb
    begin
        if (count_reg == '0)
            push_left = NBR_NONE;
        else if (mode_reg && (cell_value[0] == key_reg))
            push_left = cell_left[0];
        else
            push_left = NBR_W'(cell_pos[0]);
    end

    // Build the row of cells
    for (genvar i = 0; i < MAX_LENGTH; i++)
    begin : g_cell
        logic signed [VALUE_WIDTH-1:0] up_value, dn_value;
        logic        [POS_W-1:0]       up_pos, dn_pos;
        logic        [NBR_W-1:0]       up_left, dn_left;

        if (i == 0)
        begin : g_top
            assign up_value = key_reg;
            assign up_pos   = POS_W'(pos_reg);
            assign up_left  = push_left;
        end
        else
        begin : g_mid
            assign up_value = cell_value[i-1];
            assign up_pos   = cell_pos[i-1];
            assign up_left  = cell_left[i-1];
        end

        if (i == MAX_LENGTH - 1)
        begin : g_bottom
            assign dn_value = cell_value[i];
            assign dn_pos   = cell_pos[i];
            assign dn_left  = cell_left[i];
        end
        else
        begin : g_upper
            assign dn_value = cell_value[i+1];
            assign dn_pos   = cell_pos[i+1];
            assign dn_left  = cell_left[i+1];
        end

        nsv_cell #(
            .VALUE_WIDTH(VALUE_WIDTH),
            .POS_W      (POS_W),
            .NBR_W      (NBR_W)
        ) u_cell (
            .clk     (clk),
            .shift   (shift),
            .up_value(up_value),
            .up_pos  (up_pos),
            .up_left (up_left),
            .dn_value(dn_value),
            .dn_pos  (dn_pos),
            .dn_left (dn_left),
            .value   (cell_value[i]),
            .pos     (cell_pos[i]),
            .left    (cell_left[i])
        );
    end

    // Sequencer: compare, pop, push, flush
    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        end_next       = end_reg;
        mode_next      = cfg_wr_en ? cfg_wr_data : mode_reg;
        flush_ovf_next = flush_ovf_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        shift          = '0;
        in_stall       = 1'b1;
        emit           = 1'b0;
        out_idx_next   = out_idx_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SCAN:
            begin
                if (length_ovf)
                begin
                    if (end_reg)
                    begin
                        flush_ovf_next = 1'b1;
                        state_next     = ST_FLUSH;
                    end
                    else if (out_free)
                    begin
                        emit           = 1'b1;
                        out_idx_next   = '0;
                        out_left_next  = '0;
                        out_right_next = '0;
                        out_ovf_next   = 1'b1;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (top_gt)
                begin
                    // Pop the top with this sample as its right neighbor
                    if (out_free)
                    begin
                        emit           = 1'b1;
                        out_idx_next   = IDX_W'(cell_pos[0]);
                        out_left_next  = cell_left[0];
                        out_right_next = NBR_W'(pos_reg);
                        out_ovf_next   = 1'b0;
                        out_last_next  = !end_reg && !next_gt;
                        shift.pop      = 1'b1;
                        count_next     = count_reg - CNT_ONE;
                    end
                end
                else
                begin
                    // Push, and take the next sample in the same cycle unless this one ends the sequence
                    shift.push = 1'b1;
                    count_next = count_reg + CNT_ONE;
                    pos_next   = pos_reg + CNT_ONE;
                    if (end_reg)
                    begin
                        flush_ovf_next = 1'b0;
                        state_next     = ST_FLUSH;
                    end
                    else
                    begin
                        in_stall   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    out_ovf_next   = flush_ovf_reg;
                    if (count_reg == '0)
                    begin
                        // Overflowed end with nothing stacked
                        out_idx_next   = '0;
                        out_left_next  = '0;
                        out_right_next = '0;
                        out_last_next  = 1'b1;
                        pos_next       = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next   = IDX_W'(cell_pos[0]);
                        out_left_next  = cell_left[0];
                        out_right_next = NBR_NONE;
                        out_last_next  = (count_reg == CNT_ONE);
                        shift.pop      = 1'b1;
                        count_next     = count_reg - CNT_ONE;
                        if (count_reg == CNT_ONE)
                        begin
                            pos_next   = '0;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Load a new request
        if (in_valid && !in_stall)
        begin
            key_next   = sample_value;
            end_next   = sequence_end;
            state_next = ST_SCAN;
        end
    end

    // Hold a result until taken, refill when free
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b1;
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            flush_ovf_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            flush_ovf_reg <= flush_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        end_reg       <= end_next;
        out_idx_reg   <= out_idx_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign element_index = out_idx_reg;
    assign left_smaller  = out_left_reg;
    assign right_smaller = out_right_reg;
    assign overflow      = out_ovf_reg;
    assign last_of_item  = out_last_reg;

    // Stack depth stays within the cells and never exceeds the position
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_MAX) && (count_reg <= pos_reg))
        else $error("stack depth out of range");

    // No request taken while flushing
    a_no_accept_flush: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (state_reg != ST_FLUSH))
        else $error("request taken during flush");

    // Flushing the last entry returns to idle with the position cleared
    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && count_reg == CNT_ONE && out_free)
        |=> (state_reg == ST_IDLE && pos_reg == '0 && count_reg == '0))
        else $error("flush did not finish cleanly");

    // A result is never written over while stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !emit)
        else $error("stalled result overwritten");

endmodule

// ===== test/tb_nearest_smaller_values_stack.sv =====
`timescale 1ns / 1ps

module tb_nearest_smaller_values_stack;

    import nsv_pkg::*;

    localparam int VW           = 32;
    localparam int STACK_DEPTH  = 32;
    localparam int RANDOM_ITEMS = 350;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;

    localparam bit MODE_DISTINCT = 1'b0;
    localparam bit MODE_REPEAT   = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [NBR_W-1:0] left;
        logic [NBR_W-1:0] right;
        logic             ovf;
        logic             last;
    } nsv_result_t;

    // Tracks the monotonic stack and the neighbor results owed by the block
    class nsv_scoreboard;
        logic signed [VW-1:0] stk_key [STACK_DEPTH];
        logic [IDX_W-1:0]     stk_pos [STACK_DEPTH];
        logic [NBR_W-1:0]     stk_left [STACK_DEPTH];
        int                   depth;
        int                   pos;
        bit                   repeat_mode;
        nsv_result_t          pending [$];
        int                   errors;

        function new();
            depth       = 0;
            pos         = 0;
            repeat_mode = MODE_REPEAT;
            errors      = 0;
        endfunction

        function void pop_entry(logic [NBR_W-1:0] right, bit ovf);
            nsv_result_t res;
            depth--;
            res       = '0;
            res.idx   = stk_pos[depth];
            res.left  = stk_left[depth];
            res.right = right;
            res.ovf   = ovf;
            pending.insert(pending.size(), res);
        endfunction

        function void flush_stack(bit ovf);
            while (depth > 0)
                pop_entry(NBR_NONE, ovf);
            pos = 0;
        endfunction

        // Work out every result caused by one accepted request
        function void note_request(logic signed [VW-1:0] value, bit seq_end);
            logic [NBR_W-1:0] left;
            nsv_result_t      res;
            int               first;
            first = pending.size();
            if (pos >= STACK_DEPTH || depth >= STACK_DEPTH)
            begin
                // Too long: drop the value, flush only on the end marker
                if (seq_end)
                    flush_stack(1'b1);
                if (pending.size() == first)
                begin
                    res     = '0;
                    res.ovf = 1'b1;
                    pending.insert(pending.size(), res);
                end
            end
            else
            begin
                while (depth > 0 && stk_key[depth-1] > value)
                    pop_entry(NBR_W'(pos), 1'b0);
                if (depth == 0)
                    left = NBR_NONE;
                else if (repeat_mode && stk_key[depth-1] == value)
                    left = stk_left[depth-1];
                else
                    left = NBR_W'(stk_pos[depth-1]);
                stk_key[depth]  = value;
                stk_pos[depth]  = IDX_W'(pos);
                stk_left[depth] = left;
                depth++;
                pos++;
                if (seq_end)
                    flush_stack(1'b0);
            end
            // Mark the final result of this request
            if (pending.size() > first)
            begin
                res      = pending[pending.size()-1];
                res.last = 1'b1;
                pending[pending.size()-1] = res;
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, logic [NBR_W-1:0] left,
                                   logic [NBR_W-1:0] right, logic ovf, logic last);
            nsv_result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual index %0d",
                         $time, idx);
            end
            else
            begin
                want = pending.pop_front();
                compare_field("element_index", 8'(want.idx), 8'(idx));
                compare_field("left_smaller", 8'(want.left), 8'(left));
                compare_field("right_smaller", 8'(want.right), 8'(right));
                compare_field("overflow", 8'(want.ovf), 8'(ovf));
                compare_field("last_of_item", 8'(want.last), 8'(last));
            end
        endfunction
    endclass

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic                 cfg_wr_data  = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic signed [VW-1:0] sample_value = '0;
    logic                 sequence_end = 1'b0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [IDX_W-1:0]     element_index;
    logic [NBR_W-1:0]     left_smaller;
    logic [NBR_W-1:0]     right_smaller;
    logic                 overflow;
    logic                 last_of_item;

    nsv_scoreboard sb = new();
    int            burst_left  = 0;
    int            stall_style = 0;
    int            stall_left  = 0;
    int            cycle_count = 0;

    nearest_smaller_values_stack dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .sequence_end (sequence_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .element_index(element_index),
        .left_smaller (left_smaller),
        .right_smaller(right_smaller),
        .overflow     (overflow),
        .last_of_item (last_of_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result channel according to the current style
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stall_style == 1)
            out_stall <= ($urandom_range(0, 3) == 0);
        else if (stall_style == 2 && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(2, 15);
        end
        else
            out_stall <= 1'b0;
    end

    // Check every result taken by the receiver
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(element_index, left_smaller, right_smaller, overflow,
                            last_of_item);
    end

    // Abort a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_nearest_smaller_values_stack NOT OK");
        $finish;
    end

    // Offer one request, with a random gap between bursts
    task automatic send_item(input logic signed [VW-1:0] value, input bit seq_end);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(10, 30);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid     <= 1'b1;
        sample_value <= value;
        sequence_end <= seq_end;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(value, seq_end);
        burst_left--;
    endtask

    // Drop valid and let every owed result come out
    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input bit mode);
        @(posedge clk);
        cfg_wr_en      <= 1'b1;
        cfg_wr_data    <= mode;
        sb.repeat_mode = mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int                   sent;
        int                   phase_n;
        int                   phase_len;
        int                   seq_left;
        int                   seq_style;
        int                   pick;
        bit                   seq_end;
        logic signed [VW-1:0] value;
        logic signed [VW-1:0] ramp;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Repeat-aware mode from reset: extremes, pops, equal values
        stall_style = 1;
        send_item(32'sh7fffffff, 1'b0);
        send_item(32'sh80000000, 1'b0);
        send_item(32'sh00000000, 1'b0);
        send_item(32'sh00000000, 1'b0);
        send_item(32'shffffffff, 1'b0);
        send_item(32'sh00000000, 1'b0);
        send_item(32'sh7fffffff, 1'b1);
        // Single element sequence
        send_item(32'sh00000005, 1'b1);
        // Rising run with no pops, then a smaller final value
        send_item(32'sh00000001, 1'b0);
        send_item(32'sh00000002, 1'b0);
        send_item(32'sh00000003, 1'b0);
        send_item(32'sh00000000, 1'b1);
        wait_idle();

        // Distinct-value mode over equal groups
        write_mode(MODE_DISTINCT);
        stall_style = 2;
        send_item(32'sh00000003, 1'b0);
        send_item(32'sh00000003, 1'b0);
        send_item(32'sh00000001, 1'b0);
        send_item(32'sh00000003, 1'b0);
        send_item(32'sh00000003, 1'b0);
        send_item(32'sh00000003, 1'b1);
        wait_idle();

        // Random phases; a phase may stop mid-sequence so modes change there too
        sent      = 0;
        phase_n   = 0;
        seq_left  = 0;
        seq_style = 0;
        ramp      = '0;
        while (sent < RANDOM_ITEMS)
        begin
            write_mode(phase_n == 0 ? MODE_REPEAT : bit'($urandom_range(0, 1)));
            stall_style = $urandom_range(0, 2);
            phase_len   = $urandom_range(30, 70);
            if (phase_len > RANDOM_ITEMS - sent)
                phase_len = RANDOM_ITEMS - sent;
            repeat (phase_len)
            begin
                // Start a new sequence: mostly short, a few deep or overlong
                if (seq_left == 0)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        seq_left = $urandom_range(1, 10);
                    else if (pick < 88)
                        seq_left = $urandom_range(11, 32);
                    else
                        seq_left = $urandom_range(33, 40);
                    seq_style = $urandom_range(0, 3);
                    ramp      = -$signed(VW'($urandom_range(0, 1000)));
                end
                case (seq_style)
                    0: value = $signed(VW'($urandom_range(0, 6))) - 3;
                    1: value = $urandom;
                    2:
                    begin
                        pick = $urandom_range(0, 4);
                        if (pick == 0)
                            value = 32'sh80000000;
                        else if (pick == 1)
                            value = 32'sh7fffffff;
                        else if (pick == 2)
                            value = '0;
                        else if (pick == 3)
                            value = 32'shffffffff;
                        else
                            value = $urandom_range(0, 3);
                    end
                    default:
                    begin
                        // Mostly rising run to build a deep stack
                        if ($urandom_range(0, 15) == 0)
                            ramp = ramp - $urandom_range(1, 8);
                        else
                            ramp = ramp + $urandom_range(0, 2);
                        value = ramp;
                    end
                endcase
                // Occasionally cut a sequence short
                seq_end = (seq_left == 1) || ($urandom_range(0, 49) == 0);
                seq_left = seq_end ? 0 : seq_left - 1;
                send_item(value, seq_end);
                sent++;
            end
            wait_idle();
            phase_n++;
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_nearest_smaller_values_stack OK");
        else
            $display("tb_nearest_smaller_values_stack NOT OK");
        $finish;
    end

endmodule
